// ----- design/spfu_pkg.sv -----
package spfu_pkg;

    localparam logic [2:0] SB_16 = 3'd2;
    localparam logic [2:0] SB_24 = 3'd3;
    localparam logic [2:0] SB_32 = 3'd4;

    localparam logic [2:0] SB_RESET = SB_16;

    // register byte addresses (bit 2 selects the word)
    localparam logic REG_SAMPLE_BYTES = 1'b0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_start;
        logic       stream_end;
    } in_t;

    typedef struct packed {
        logic [31:0] left_float;
        logic [31:0] right_float;
        logic        last_frame;
    } out_t;

    // one completed frame, raw little-endian samples
    typedef struct packed {
        logic [31:0] left_raw;
        logic [31:0] right_raw;
        logic        last;
        logic [2:0]  sb;
    } frame_t;

    function automatic logic [5:0] lead_zeros(input logic [31:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'd32;
        found = 1'b0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!found && v[i])
            begin
                n     = 6'(31 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ----- design/spfu_assemble.sv -----
module spfu_assemble (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  spfu_pkg::in_t      in_data,
    input  logic [2:0]         sample_bytes,
    output logic               frame_done,
    output spfu_pkg::frame_t   frame
);

    logic [2:0]  pos_reg, pos_next;
    logic [31:0] left_hold_reg, left_hold_next;
    logic [23:0] right_partial_reg, right_partial_next;

    logic [31:0] lh;
    logic [23:0] rp;
    logic [2:0]  pos;
    logic [2:0]  r;
    logic [31:0] low_mask;
    logic        supported;

    always_comb
    begin
        lh                 = in_data.stream_start ? 32'd0 : left_hold_reg;
        rp                 = in_data.stream_start ? 24'd0 : right_partial_reg;
        pos                = in_data.stream_start ? 3'd0 : pos_reg;
        supported          = (sample_bytes == spfu_pkg::SB_16) ||
                             (sample_bytes == spfu_pkg::SB_24) ||
                             (sample_bytes == spfu_pkg::SB_32);
        frame_done         = 1'b0;
        r                  = 3'd0;
        low_mask           = 32'd0;
        left_hold_next     = lh;
        right_partial_next = rp;
        pos_next           = pos;
        frame.left_raw     = lh;
        frame.right_raw    = 32'd0;
        frame.last         = in_data.stream_end;
        frame.sb           = sample_bytes;

        if (!supported)
        begin
            pos_next = 3'd0;
        end
        else
        begin
            if ({1'b0, pos} >= {sample_bytes, 1'b0})
            begin
                pos = 3'd0;
            end
            if (pos < sample_bytes)
            begin
                left_hold_next[pos[1:0]*8 +: 8] = in_data.data_byte;
                pos_next = in_data.stream_end ? 3'd0 : pos + 3'd1;
            end
            else
            begin
                r = pos - sample_bytes;
                if (r < sample_bytes - 3'd1)
                begin
                    right_partial_next[r[1:0]*8 +: 8] = in_data.data_byte;
                    pos_next = in_data.stream_end ? 3'd0 : pos + 3'd1;
                end
                else
                begin
                    // last byte of the frame: hand both samples on
                    low_mask = (32'd1 << {r[1:0], 3'b000}) - 32'd1;
                    frame.right_raw = ({8'd0, rp} & low_mask) |
                                      ({24'd0, in_data.data_byte} << {r[1:0], 3'b000});
                    frame_done = 1'b1;
                    pos_next   = 3'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg           <= 3'd0;
            left_hold_reg     <= 32'd0;
            right_partial_reg <= 24'd0;
        end
        else if (take)
        begin
            pos_reg           <= pos_next;
            left_hold_reg     <= left_hold_next;
            right_partial_reg <= right_partial_next;
        end
    end

endmodule

// ----- design/spfu_cvt.sv -----
module spfu_cvt (
    input  logic [31:0] raw,
    input  logic [2:0]  sample_bytes,
    output logic [31:0] result
);

    logic [31:0] sval;
    logic [31:0] mag;
    logic [31:0] norm;
    logic [5:0]  lz;
    logic [24:0] keep;
    logic        rnd;
    logic [8:0]  expo;
    logic [8:0]  bias_adj;
    logic        sign;

    always_comb
    begin
        case (sample_bytes)
            spfu_pkg::SB_16: begin sval = {{16{raw[15]}}, raw[15:0]}; bias_adj = 9'd15; end
            spfu_pkg::SB_24: begin sval = {{8{raw[23]}}, raw[23:0]};  bias_adj = 9'd23; end
            default:         begin sval = raw;                         bias_adj = 9'd31; end
        endcase
        sign = sval[31];
        mag  = sign ? (~sval + 32'd1) : sval;
        lz   = spfu_pkg::lead_zeros(mag);
        norm = mag << lz[4:0];
        // round to nearest, ties to even
        rnd  = norm[7] && ((norm[6:0] != 7'd0) || norm[8]);
        keep = {1'b0, norm[31:8]} + {24'd0, rnd};
        expo = 9'd158 - {3'd0, lz} - bias_adj + {8'd0, keep[24]};
        if (mag == 32'd0)
        begin
            result = 32'd0;
        end
        else
        begin
            result = {sign, expo[7:0], keep[24] ? keep[23:1] : keep[22:0]};
        end
    end

endmodule

// ----- design/stereo_pcm_to_float_unpacker.sv -----
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_stall   | in_data  (data_byte, stream_start, stream_end)
// out     | out | out_valid/out_stall | out_data (left_float, right_float, last_frame)
// cfg     | in  | APB                 | sample_bytes at byte address 0
//
// One byte per cycle sustained while in_stall is low; a frame's result passes through both stages below.
// Stages: byte assembly into a frame register, then float conversion into the output register.
// rst_n clears positions, held bytes, valid flags, and sample_bytes to 2 (16-bit).
// A stalled output holds the frame register; input stalls only when both are full.
module stereo_pcm_to_float_unpacker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  spfu_pkg::in_t    in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output spfu_pkg::out_t   out_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [2:0]        sample_bytes_reg;
    logic              frame_v_reg;
    spfu_pkg::frame_t  frame_reg;
    logic              out_valid_reg;
    spfu_pkg::out_t    out_reg;

    logic              take;
    logic              out_ready;
    logic              frame_done;
    spfu_pkg::frame_t  frame_new;
    logic [31:0]       left_f, right_f;

    // config port: write in the access phase, always ready
    assign pready = 1'b1;
    assign prdata = (paddr[2] == spfu_pkg::REG_SAMPLE_BYTES) ? {29'd0, sample_bytes_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_bytes_reg <= spfu_pkg::SB_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == spfu_pkg::REG_SAMPLE_BYTES))
        begin
            sample_bytes_reg <= pwdata[2:0];
        end
    end

    // output stage drains when empty or taken; frame stage moves when output can load
    assign out_ready = !out_valid_reg || !out_stall;
    assign in_stall  = frame_v_reg && !out_ready;
    assign take      = in_valid && !in_stall;

    spfu_assemble u_asm (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .in_data      (in_data),
        .sample_bytes (sample_bytes_reg),
        .frame_done   (frame_done),
        .frame        (frame_new)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_v_reg <= 1'b0;
        end
        else if (!frame_v_reg || out_ready)
        begin
            frame_v_reg <= take && frame_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && frame_done)
        begin
            frame_reg <= frame_new;
        end
    end

    spfu_cvt u_cvt_l (
        .raw          (frame_reg.left_raw),
        .sample_bytes (frame_reg.sb),
        .result       (left_f)
    );

    spfu_cvt u_cvt_r (
        .raw          (frame_reg.right_raw),
        .sample_bytes (frame_reg.sb),
        .result       (right_f)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= frame_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && frame_v_reg)
        begin
            out_reg.left_float  <= left_f;
            out_reg.right_float <= right_f;
            out_reg.last_frame  <= frame_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_v_reg && out_valid_reg && out_stall) |-> in_stall)
        else $error("input accepted with both stages full");

    a_frame_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_v_reg && out_ready) |=> out_valid_reg)
        else $error("frame lost on transfer to output");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(frame_v_reg))
        else $error("result without a frame");

endmodule

// ----- test/stereo_pcm_to_float_unpacker_checker.sv -----
module stereo_pcm_to_float_unpacker_checker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  spfu_pkg::in_t           in_data,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  spfu_pkg::out_t          out_data,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    input  logic                    pready,
    output int                      fail_count,
    output int                      frames_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [2:0]      cur_size;
    logic [2:0]      frame_pos;
    logic [31:0]     left_bytes;
    logic [23:0]     right_bytes;
    spfu_pkg::out_t  frame_q[$];

    assign frames_pending = frame_q.size();

    // scale a signed sample of nbits by 2^-(nbits-1), round to nearest even
    function automatic logic [31:0] to_single(input logic [31:0] raw, input int nbits);
        logic [31:0] mask;
        logic [32:0] mag;
        logic [31:0] kept;
        logic [31:0] rem;
        logic [31:0] half;
        logic        sgn;
        int          msb;
        int          sh;
        logic [7:0]  ex;
        mask = (nbits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << nbits) - 1);
        raw  = raw & mask;
        sgn  = raw[nbits-1];
        mag  = sgn ? ((33'd1 << nbits) - {1'b0, raw}) : {1'b0, raw};
        if (mag == 0)
            return 32'd0;
        msb = 0;
        for (int i = 0; i < 33; i++)
            if (mag[i])
                msb = i;
        if (msb <= 23)
            kept = mag[31:0] << (23 - msb);
        else
        begin
            sh   = msb - 23;
            rem  = mag[31:0] & ((32'd1 << sh) - 1);
            half = 32'd1 << (sh - 1);
            kept = mag[31:0] >> sh;
            if (rem > half || (rem == half && kept[0]))
                kept++;
            if (kept == 32'h0100_0000)
            begin
                kept = kept >> 1;
                msb++;
            end
        end
        ex = 8'(127 + msb - (nbits - 1));
        return {sgn, ex, kept[22:0]};
    endfunction

    // advance the frame assembly by one accepted byte
    task automatic take_byte(input spfu_pkg::in_t t);
        logic [2:0]      p;
        logic [31:0]     rhs;
        int              r;
        spfu_pkg::out_t  f;
        if (t.stream_start)
        begin
            frame_pos   = 0;
            left_bytes  = 0;
            right_bytes = 0;
        end
        if (cur_size < 2 || cur_size > 4)
        begin
            frame_pos = 0;
            return;
        end
        p = frame_pos;
        if (p >= 2 * cur_size)
            p = 0;
        if (p < cur_size)
        begin
            left_bytes[8*p +: 8] = t.data_byte;
            p++;
        end
        else
        begin
            r = p - cur_size;
            if (r < cur_size - 1)
            begin
                right_bytes[8*r +: 8] = t.data_byte;
                p++;
            end
            else
            begin
                rhs = {8'd0, right_bytes} & ((32'd1 << (8*r)) - 1);
                rhs[8*r +: 8] = t.data_byte;
                f.left_float  = to_single(left_bytes, 8*cur_size);
                f.right_float = to_single(rhs, 8*cur_size);
                f.last_frame  = t.stream_end;
                frame_q.push_back(f);
                frame_pos = 0;
                return;
            end
        end
        frame_pos = t.stream_end ? 3'd0 : p;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        spfu_pkg::out_t e;
        if (!rst_n)
        begin
            cur_size    = spfu_pkg::SB_RESET;
            frame_pos   = 0;
            left_bytes  = 0;
            right_bytes = 0;
            fail_count  = 0;
            frame_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == spfu_pkg::REG_SAMPLE_BYTES)
                cur_size = pwdata[2:0];
            if (in_valid && !in_stall)
                take_byte(in_data);
            if (out_valid && !out_stall)
            begin
                if (frame_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected frame %h", out_data);
                end
                else
                begin
                    e = frame_q.pop_front();
                    if (e !== out_data)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("frame mismatch: expected L=%h R=%h last=%b, got L=%h R=%h last=%b",
                                     e.left_float, e.right_float, e.last_frame,
                                     out_data.left_float, out_data.right_float,
                                     out_data.last_frame);
                    end
                end
            end
        end
    end
endmodule

// ----- test/stereo_pcm_to_float_unpacker_tb.sv -----
module stereo_pcm_to_float_unpacker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    spfu_pkg::in_t   in_data;
    logic            out_valid;
    logic            out_stall;
    spfu_pkg::out_t  out_data;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [2:0]      paddr;
    logic [31:0]     pwdata;
    logic [31:0]     prdata;
    logic            pready;
    int              fail_count;
    int              frames_pending;

    // receiver behavior, steered by the stimulus process
    bit          hold_off;     // long stall stretch for backpressure
    bit          calm;         // no idling in the tail of the run
    int          cycle_count;

    localparam int CYCLE_LIMIT = 400000;

    stereo_pcm_to_float_unpacker dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    stereo_pcm_to_float_unpacker_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .frames_pending(frames_pending)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // timeout watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("stereo_pcm_to_float_unpacker verification failed");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, plus a long hold-off when asked
    initial
    begin
        int n;
        out_stall = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_stall <= 1;
                for (int i = 0; i < 300; i++)
                    @(posedge clk);
                hold_off = 0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1;
                n = $urandom_range(1, 17);
                repeat (n) @(posedge clk);
            end
            else
            begin
                out_stall <= 0;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge clk);
            end
        end
    end

    // hold the byte until the transfer completes, then drop valid or keep it up
    task automatic send_byte(input logic [7:0] b, input logic st, input logic en);
        int gap;
        in_valid <= 1;
        in_data  <= '{data_byte: b, stream_start: st, stream_end: en};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(posedge clk);
        end
    endtask

    // APB write with setup and access phases, issued only with the block drained
    task automatic write_size(input logic [2:0] v);
        in_valid <= 0;
        @(posedge clk);
        while (frames_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        psel    <= 1;
        pwrite  <= 1;
        paddr   <= {spfu_pkg::REG_SAMPLE_BYTES, 2'b00};
        pwdata  <= {$urandom} & 32'hFFFF_FFF8 | 32'(v);
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        @(posedge clk);
    endtask

    // one well-formed frame of random or chosen samples
    task automatic send_frame(input int sb, input logic [31:0] l, input logic [31:0] r,
                              input logic st, input logic en);
        for (int i = 0; i < 2 * sb; i++)
            send_byte(i < sb ? l[8*i +: 8] : r[8*(i-sb) +: 8],
                      st && i == 0, en && i == 2 * sb - 1);
    endtask

    initial
    begin
        logic [2:0] sizes[6];
        int         sb;
        int         k;
        rst_n    = 0;
        in_valid = 0;
        in_data  = '0;
        psel     = 0;
        penable  = 0;
        pwrite   = 0;
        paddr    = 0;
        pwdata   = 0;
        hold_off = 0;
        calm     = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes per size, zero, start resync, end mid-frame
        send_frame(2, 32'h0000_8000, 32'h0000_7FFF, 1, 0);
        send_frame(2, 32'h0, 32'h0000_FFFF, 0, 1);
        send_byte(8'hAA, 0, 0);
        send_frame(2, 32'h0000_0001, 32'h0000_8001, 1, 0);
        write_size(spfu_pkg::SB_32);
        send_frame(4, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0);
        send_frame(4, 32'h0100_0001, 32'hFFFF_FFFF, 0, 0);
        send_byte(8'h12, 0, 0);
        send_byte(8'h34, 0, 1);          // end inside a frame
        write_size(spfu_pkg::SB_24);
        send_frame(3, 32'h80_0000, 32'h7F_FFFF, 0, 1);
        send_byte(8'h55, 0, 0);
        send_byte(8'h66, 0, 0);
        write_size(3'd7);                // unsupported size drops bytes
        send_byte(8'hFF, 1, 1);
        send_byte(8'h00, 0, 0);
        write_size(spfu_pkg::SB_32);     // leave seven bytes of a frame pending
        for (int i = 0; i < 7; i++)
            send_byte(8'(i), i == 0, 0);
        write_size(spfu_pkg::SB_24);     // stale position now restarts
        send_frame(3, 32'h12_3456, 32'hFE_DCBA, 0, 0);

        // random: mostly well-formed frames, some noise, every size incl. bad
        sizes = '{spfu_pkg::SB_16, spfu_pkg::SB_32, 3'd0, spfu_pkg::SB_24, 3'd1,
                  spfu_pkg::SB_16};
        k = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_size(sizes[ph]);
            sb = (sizes[ph] < 2 || sizes[ph] > 4) ? 2 : sizes[ph];
            if (ph == 5)
                calm = 1;
            for (int fr = 0; k < 1050 && fr < (sb == 2 && sizes[ph] >= 2 ? 50 : 30); fr++)
            begin
                if (ph == 1 && fr == 5)
                    hold_off = 1;
                if ($urandom_range(0, 7) == 0)
                begin
                    send_byte(8'($urandom), 1'($urandom), 1'($urandom));
                    k++;
                end
                else
                begin
                    send_frame(sb, $urandom, $urandom, $urandom_range(0, 3) == 0,
                               $urandom_range(0, 7) == 0);
                    k += 2 * sb;
                end
            end
        end
        while (k < 1050)
        begin
            send_frame(2, $urandom, $urandom, 0, 0);
            k += 4;
        end

        in_valid <= 0;
        @(posedge clk);
        while (frames_pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("stereo_pcm_to_float_unpacker verification clean");
        else
            $display("stereo_pcm_to_float_unpacker verification failed");
        $finish;
    end
endmodule
